@@ src/bfd_control_packet_receive_check_defines.svh @@
// assertion macros for the bfd receive check top level
`ifndef BFD_CONTROL_PACKET_RECEIVE_CHECK_DEFINES_SVH
`define BFD_CONTROL_PACKET_RECEIVE_CHECK_DEFINES_SVH

`ifndef SYNTHESIS
// property checked while out of reset
`define BFDRC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property checked at every edge, reset included
`define BFDRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BFDRC_ASSERT(lbl, clk, rst_n, prop, msg)
`define BFDRC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ src/bfdrc_pkg.sv @@
package bfdrc_pkg;

  localparam int NUM_SESSIONS = 16;
  localparam int SESS_IW = (NUM_SESSIONS > 1) ? $clog2(NUM_SESSIONS) : 1;
  localparam int SESS_CW = 11;

  localparam int IN_TDATA_W  = 240;
  localparam int OUT_TDATA_W = 72;

  localparam logic [2:0] PROTO_VERSION = 3'd1;
  localparam logic [4:0] DIAG_MAX      = 5'd8;
  localparam logic [7:0] PKT_LENGTH    = 8'd24;
  localparam logic [1:0] ST_ADMIN_DOWN = 2'd0;
  localparam logic [1:0] ST_DOWN       = 2'd1;

  // 2^38 / 1000 rounded up, exact for any 32-bit dividend after >> 38
  localparam logic [28:0] MS_MAGIC = 29'd274877907;
  localparam int          MS_SHIFT = 38;

  // status codes; state out of range cannot happen with a two-bit state
  localparam logic [3:0] STAT_OK         = 4'd0;
  localparam logic [3:0] STAT_VERSION    = 4'd1;
  localparam logic [3:0] STAT_DIAG       = 4'd2;
  localparam logic [3:0] STAT_POLL_FINAL = 4'd4;
  localparam logic [3:0] STAT_AUTH       = 4'd5;
  localparam logic [3:0] STAT_DEMAND     = 4'd6;
  localparam logic [3:0] STAT_MULTIPOINT = 4'd7;
  localparam logic [3:0] STAT_ZERO_MULT  = 4'd8;
  localparam logic [3:0] STAT_LENGTH     = 4'd9;
  localparam logic [3:0] STAT_ZERO_SDISC = 4'd10;
  localparam logic [3:0] STAT_RDISC      = 4'd11;
  localparam logic [3:0] STAT_ECHO       = 4'd12;

  // change mask bit positions
  localparam int CHG_DIAG  = 0;
  localparam int CHG_STATE = 1;
  localparam int CHG_MULT  = 2;
  localparam int CHG_DISCR = 3;
  localparam int CHG_TX    = 4;
  localparam int CHG_RX    = 5;

  typedef struct packed {
    logic [3:0]  session;
    logic        sess_ok;
    logic [3:0]  status;
    logic [4:0]  diag;
    logic [1:0]  state;
    logic [7:0]  mult;
    logic [31:0] sender_discr;
    logic [22:0] tx_ms;
    logic [22:0] rx_ms;
    logic [7:0]  fire_count;
  } decoded_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        restart_tx_timer;
    logic        restart_detect_timer;
    logic [7:0]  fire_count_out;
    logic [5:0]  change_mask;
    logic [22:0] remote_tx_ms;
    logic [22:0] remote_rx_ms;
  } result_t;

endpackage

@@ src/bfdrc_decode.sv @@
module bfdrc_decode (
  input  logic                               clk,
  input  logic                               load,
  input  logic [bfdrc_pkg::IN_TDATA_W-1:0]   in_word,
  output bfdrc_pkg::decoded_t                dec
);
  import bfdrc_pkg::*;

  logic [3:0]  session;
  logic [31:0] hdr;
  logic [31:0] sdis;
  logic [31:0] rdis;
  logic [31:0] tx_us;
  logic [31:0] rx_us;
  logic [31:0] echo;
  logic [31:0] ldis;
  logic [7:0]  fire;
  logic [60:0] tx_prod;
  logic [60:0] rx_prod;
  logic [3:0]  status;
  decoded_t    dec_nxt;
  decoded_t    dec_r;

  assign session = in_word[3:0];
  assign hdr     = in_word[35:4];
  assign sdis    = in_word[67:36];
  assign rdis    = in_word[99:68];
  assign tx_us   = in_word[131:100];
  assign rx_us   = in_word[163:132];
  assign echo    = in_word[195:164];
  assign ldis    = in_word[227:196];
  assign fire    = in_word[235:228];

  // divide by 1000 as multiply by reciprocal
  assign tx_prod = {29'd0, tx_us} * {32'd0, MS_MAGIC};
  assign rx_prod = {29'd0, rx_us} * {32'd0, MS_MAGIC};

  // checks in priority order, first failure wins
  always_comb begin
    status = STAT_OK;
    if (hdr[31:29] != PROTO_VERSION) begin
      status = STAT_VERSION;
    end else if (hdr[28:24] > DIAG_MAX) begin
      status = STAT_DIAG;
    end else if (hdr[21] && hdr[20]) begin
      status = STAT_POLL_FINAL;
    end else if (hdr[18]) begin
      status = STAT_AUTH;
    end else if (hdr[17]) begin
      status = STAT_DEMAND;
    end else if (hdr[16]) begin
      status = STAT_MULTIPOINT;
    end else if (hdr[15:8] == 8'd0) begin
      status = STAT_ZERO_MULT;
    end else if (hdr[7:0] != PKT_LENGTH) begin
      status = STAT_LENGTH;
    end else if (sdis == 32'd0) begin
      status = STAT_ZERO_SDISC;
    end else if ((rdis == 32'd0) && (hdr[23:22] != ST_ADMIN_DOWN) &&
                 (hdr[23:22] != ST_DOWN)) begin
      status = STAT_RDISC;
    end else if ((rdis != 32'd0) && (rdis != ldis)) begin
      status = STAT_RDISC;
    end else if (echo != 32'd0) begin
      status = STAT_ECHO;
    end
  end

  always_comb begin
    dec_nxt.session      = session;
    dec_nxt.sess_ok      = {7'd0, session} < SESS_CW'(NUM_SESSIONS);
    dec_nxt.status       = status;
    dec_nxt.diag         = hdr[28:24];
    dec_nxt.state        = hdr[23:22];
    dec_nxt.mult         = hdr[15:8];
    dec_nxt.sender_discr = sdis;
    dec_nxt.tx_ms        = tx_prod[MS_SHIFT+22:MS_SHIFT];
    dec_nxt.rx_ms        = rx_prod[MS_SHIFT+22:MS_SHIFT];
    dec_nxt.fire_count   = fire;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dec_r <= dec_nxt;
    end
  end

  assign dec = dec_r;

endmodule

@@ src/bfdrc_session_table.sv @@
module bfdrc_session_table (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  bfdrc_pkg::decoded_t  dec,
  output bfdrc_pkg::result_t   res
);
  import bfdrc_pkg::*;

  logic [4:0]  diag_r  [NUM_SESSIONS];
  logic [1:0]  state_r [NUM_SESSIONS];
  logic [7:0]  mult_r  [NUM_SESSIONS];
  logic [31:0] discr_r [NUM_SESSIONS];
  logic [22:0] tx_r    [NUM_SESSIONS];
  logic [22:0] rx_r    [NUM_SESSIONS];

  logic [SESS_IW-1:0] idx;
  logic               upd;
  logic [4:0]         cur_diag;
  logic [1:0]         cur_state;
  logic [7:0]         cur_mult;
  logic [31:0]        cur_discr;
  logic [22:0]        cur_tx;
  logic [22:0]        cur_rx;
  logic [5:0]         mask;
  logic [7:0]         fire;
  result_t            res_nxt;
  result_t            res_r;

  assign idx = SESS_IW'(dec.session);
  assign upd = dec.sess_ok && (dec.status == STAT_OK);

  // out-of-range sessions read as zero
  always_comb begin
    cur_diag  = '0;
    cur_state = '0;
    cur_mult  = '0;
    cur_discr = '0;
    cur_tx    = '0;
    cur_rx    = '0;
    if (dec.sess_ok) begin
      cur_diag  = diag_r[idx];
      cur_state = state_r[idx];
      cur_mult  = mult_r[idx];
      cur_discr = discr_r[idx];
      cur_tx    = tx_r[idx];
      cur_rx    = rx_r[idx];
    end
  end

  always_comb begin
    mask = '0;
    fire = dec.fire_count;
    if (upd) begin
      mask[CHG_DIAG]  = dec.diag != cur_diag;
      mask[CHG_STATE] = dec.state != cur_state;
      mask[CHG_MULT]  = dec.mult != cur_mult;
      mask[CHG_DISCR] = dec.sender_discr != cur_discr;
      mask[CHG_TX]    = dec.tx_ms != cur_tx;
      mask[CHG_RX]    = dec.rx_ms != cur_rx;
      // new multiplier is never zero here
      if (mask[CHG_MULT] && (dec.fire_count >= dec.mult)) begin
        fire = dec.mult - 8'd1;
      end
    end
    res_nxt.status               = dec.status;
    res_nxt.restart_tx_timer     = mask[CHG_RX];
    res_nxt.restart_detect_timer = mask[CHG_MULT] | mask[CHG_TX];
    res_nxt.fire_count_out       = fire;
    res_nxt.change_mask          = mask;
    res_nxt.remote_tx_ms         = upd ? dec.tx_ms : cur_tx;
    res_nxt.remote_rx_ms         = upd ? dec.rx_ms : cur_rx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SESSIONS; i++) begin
        diag_r[i]  <= '0;
        state_r[i] <= '0;
        mult_r[i]  <= '0;
        discr_r[i] <= '0;
        tx_r[i]    <= '0;
        rx_r[i]    <= '0;
      end
    end else if (load && upd) begin
      diag_r[idx]  <= dec.diag;
      state_r[idx] <= dec.state;
      mult_r[idx]  <= dec.mult;
      discr_r[idx] <= dec.sender_discr;
      tx_r[idx]    <= dec.tx_ms;
      rx_r[idx]    <= dec.rx_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

@@ src/bfd_control_packet_receive_check.sv @@
// path: an accepted word goes through the decode register, then the result register,
//   before it shows on out_tdata
// throughput: one word per cycle while out_tready stays high, set by the decode
//   stage and the session table update
// reset: synchronous active-low rst_n clears both valid flags and sets every
//   session's stored remote values to zero; no clearing pass is needed
module bfd_control_packet_receive_check (
  input  logic                                clk,
  input  logic                                rst_n,
  // session[3:0], header_word[35:4], sender_discr[67:36], receiver_discr[99:68],
  // desired_tx_us[131:100], required_rx_us[163:132], echo_rx_us[195:164],
  // local_discr[227:196], fire_count[235:228], zero pad[239:236]
  input  logic [bfdrc_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // status[3:0], restart_tx_timer[4], restart_detect_timer[5],
  // fire_count_out[13:6], change_mask[19:14], remote_tx_ms[42:20],
  // remote_rx_ms[65:43], zero pad[71:66]
  output logic [bfdrc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready
);
  import bfdrc_pkg::*;

`include "bfd_control_packet_receive_check_defines.svh"

  // decode stage holds one word, the result register another
  logic       dec_vld_r;
  logic       dec_vld_nxt;
  logic       out_vld_r;
  logic       out_vld_nxt;
  logic       out_room;
  logic       dec_adv;
  logic       in_acc;
  decoded_t   dec;
  result_t    res;

  // result register is free when empty or being drained this cycle
  assign out_room  = !out_vld_r || out_tready;
  assign dec_adv   = dec_vld_r && out_room;
  assign in_tready = !dec_vld_r || out_room;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    dec_vld_nxt = dec_vld_r;
    if (in_acc) begin
      dec_vld_nxt = 1'b1;
    end else if (dec_adv) begin
      dec_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (dec_adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      dec_vld_r <= dec_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // field checks and interval conversion to ms
  bfdrc_decode u_decode (
    .clk     (clk),
    .load    (in_acc),
    .in_word (in_tdata),
    .dec     (dec)
  );

  // per-session compare, update and result register; the table is written
  // at the same edge the word moves on, so the next word sees fresh values
  bfdrc_session_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (dec_adv),
    .dec   (dec),
    .res   (res)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, res.remote_rx_ms, res.remote_tx_ms, res.change_mask,
                       res.fire_count_out, res.restart_detect_timer,
                       res.restart_tx_timer, res.status};

  `BFDRC_ASSERT_ALWAYS(a_out_idle_after_reset, clk, !rst_n |=> !out_tvalid, "result valid right after reset")
  `BFDRC_ASSERT(a_fail_no_change, clk, rst_n, (out_tvalid && (res.status != STAT_OK)) |-> ((res.change_mask == 6'd0) && !res.restart_tx_timer && !res.restart_detect_timer), "failed packet reported a change")
  `BFDRC_ASSERT(a_detect_restart, clk, rst_n, out_tvalid |-> (res.restart_detect_timer == (res.change_mask[CHG_MULT] | res.change_mask[CHG_TX])), "detect restart disagrees with mask")
  `BFDRC_ASSERT(a_tx_restart, clk, rst_n, out_tvalid |-> (res.restart_tx_timer == res.change_mask[CHG_RX]), "tx restart disagrees with mask")

endmodule

@@ tb/sv/tb_bfd_control_packet_receive_check.sv @@
module tb_bfd_control_packet_receive_check;
  import bfdrc_pkg::*;

  // packet states without a constant in the package
  localparam logic [1:0] ST_INIT = 2'd2;
  localparam logic [1:0] ST_UP   = 2'd3;

  // flag positions inside the six-bit P F C A D M group
  localparam int FLG_P = 5;
  localparam int FLG_F = 4;
  localparam int FLG_C = 3;
  localparam int FLG_A = 2;
  localparam int FLG_D = 1;
  localparam int FLG_M = 0;

  localparam int TAIL_CYCLES = 8;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [3:0]  session;
    logic [31:0] header_word;
    logic [31:0] sender_discr;
    logic [31:0] receiver_discr;
    logic [31:0] desired_tx_us;
    logic [31:0] required_rx_us;
    logic [31:0] echo_rx_us;
    logic [31:0] local_discr;
    logic [7:0]  fire_count;
  } bfd_pkt_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;

  // per-session remote values as the block should hold them
  logic [4:0]  diag_store[NUM_SESSIONS];
  logic [1:0]  state_store[NUM_SESSIONS];
  logic [7:0]  mult_store[NUM_SESSIONS];
  logic [31:0] discr_store[NUM_SESSIONS];
  logic [22:0] tx_ms_store[NUM_SESSIONS];
  logic [22:0] rx_ms_store[NUM_SESSIONS];

  // local discriminator handed in with each session's packets
  logic [31:0] local_id[NUM_SESSIONS];

  result_t     expected_replies[$];
  int unsigned fail_count = 0;

  // sender and receiver idling controls
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int hold_req  = 0;
  int hold_left = 0;

  bfd_control_packet_receive_check u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit, far above the slowest legal run
  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

  // header word: version, diag, state, P F C A D M, mult, length
  function automatic logic [31:0] make_header(input logic [2:0] ver, input logic [4:0] diag,
                                              input logic [1:0] st, input logic [5:0] flags,
                                              input logic [7:0] mult, input logic [7:0] len);
    return {ver, diag, st, flags, mult, len};
  endfunction

  // expected reply for one packet; updates the session copy on success
  function automatic result_t predict_reply(input bfd_pkt_t p);
    result_t     r;
    logic [2:0]  ver;
    logic [4:0]  diag;
    logic [1:0]  st;
    logic [5:0]  flags;
    logic [7:0]  mult;
    logic [7:0]  len;
    logic [22:0] tx_ms;
    logic [22:0] rx_ms;
    {ver, diag, st, flags, mult, len} = p.header_word;
    tx_ms = 23'(p.desired_tx_us / 32'd1000);
    rx_ms = 23'(p.required_rx_us / 32'd1000);
    r = '0;
    r.fire_count_out = p.fire_count;

    // checks in fixed order, first failure wins
    if (ver != PROTO_VERSION)                  r.status = STAT_VERSION;
    else if (diag > DIAG_MAX)                  r.status = STAT_DIAG;
    else if (flags[FLG_P] && flags[FLG_F])     r.status = STAT_POLL_FINAL;
    else if (flags[FLG_A])                     r.status = STAT_AUTH;
    else if (flags[FLG_D])                     r.status = STAT_DEMAND;
    else if (flags[FLG_M])                     r.status = STAT_MULTIPOINT;
    else if (mult == 8'd0)                     r.status = STAT_ZERO_MULT;
    else if (len != PKT_LENGTH)                r.status = STAT_LENGTH;
    else if (p.sender_discr == 32'd0)          r.status = STAT_ZERO_SDISC;
    else if (p.receiver_discr == 32'd0 && st != ST_ADMIN_DOWN && st != ST_DOWN)
                                               r.status = STAT_RDISC;
    else if (p.receiver_discr != 32'd0 && p.receiver_discr != p.local_discr)
                                               r.status = STAT_RDISC;
    else if (p.echo_rx_us != 32'd0)            r.status = STAT_ECHO;
    else                                       r.status = STAT_OK;

    if (p.session < NUM_SESSIONS) begin
      if (r.status == STAT_OK) begin
        if (diag != diag_store[p.session]) begin
          r.change_mask[CHG_DIAG] = 1'b1;
          diag_store[p.session] = diag;
        end
        if (st != state_store[p.session]) begin
          r.change_mask[CHG_STATE] = 1'b1;
          state_store[p.session] = st;
        end
        if (mult != mult_store[p.session]) begin
          r.change_mask[CHG_MULT] = 1'b1;
          mult_store[p.session] = mult;
          if (r.fire_count_out >= mult) r.fire_count_out = mult - 8'd1;
        end
        if (p.sender_discr != discr_store[p.session]) begin
          r.change_mask[CHG_DISCR] = 1'b1;
          discr_store[p.session] = p.sender_discr;
        end
        if (tx_ms != tx_ms_store[p.session]) begin
          r.change_mask[CHG_TX] = 1'b1;
          tx_ms_store[p.session] = tx_ms;
        end
        if (rx_ms != rx_ms_store[p.session]) begin
          r.change_mask[CHG_RX] = 1'b1;
          rx_ms_store[p.session] = rx_ms;
        end
        r.restart_tx_timer     = r.change_mask[CHG_RX];
        r.restart_detect_timer = r.change_mask[CHG_MULT] | r.change_mask[CHG_TX];
      end
      r.remote_tx_ms = tx_ms_store[p.session];
      r.remote_rx_ms = rx_ms_store[p.session];
    end
    return r;
  endfunction

  // interval in microseconds: often the same millisecond value as stored
  function automatic logic [31:0] pick_us(input logic [22:0] ms);
    longint unsigned base;
    base = longint'(ms) * 1000;
    if ($urandom_range(9) < 6) begin
      if (ms == 23'd4294967) return 32'(base + $urandom_range(295));
      return 32'(base + $urandom_range(999));
    end
    if ($urandom_range(1) == 1) return $urandom_range(2000000);
    return $urandom();
  endfunction

  // well-formed packet with random content, biased toward repeats
  function automatic bfd_pkt_t gen_good_pkt(input logic [3:0] s);
    bfd_pkt_t   p;
    logic [4:0] diag;
    logic [1:0] st;
    logic [7:0] mult;
    logic [5:0] flags;
    if ($urandom_range(19) == 0) local_id[s] = $urandom();
    p.session     = s;
    p.local_discr = local_id[s];
    diag = ($urandom_range(9) < 6) ? diag_store[s] : 5'($urandom_range(DIAG_MAX));
    st   = ($urandom_range(9) < 6) ? state_store[s] : 2'($urandom_range(3));
    if (mult_store[s] != 8'd0 && $urandom_range(9) < 6) mult = mult_store[s];
    else if ($urandom_range(9) < 7) mult = 8'($urandom_range(1, 8));
    else mult = 8'($urandom_range(1, 255));
    flags = '0;
    flags[FLG_C] = 1'($urandom_range(1));
    case ($urandom_range(2))
      1: flags[FLG_P] = 1'b1;
      2: flags[FLG_F] = 1'b1;
      default: ;
    endcase
    p.header_word = make_header(PROTO_VERSION, diag, st, flags, mult, PKT_LENGTH);
    if (discr_store[s] != 32'd0 && $urandom_range(9) < 6) p.sender_discr = discr_store[s];
    else p.sender_discr = $urandom();
    if (p.sender_discr == 32'd0) p.sender_discr = 32'd1;
    // zero your-discriminator only legal while down
    if ((st == ST_ADMIN_DOWN || st == ST_DOWN) && $urandom_range(1) == 1)
      p.receiver_discr = '0;
    else
      p.receiver_discr = p.local_discr;
    p.desired_tx_us  = pick_us(tx_ms_store[s]);
    p.required_rx_us = pick_us(rx_ms_store[s]);
    p.echo_rx_us     = '0;
    p.fire_count     = 8'($urandom());
    return p;
  endfunction

  // spoil one check of a well-formed packet, or only toggle the C flag
  function automatic bfd_pkt_t break_pkt(input bfd_pkt_t p);
    logic [3:0] which;
    logic [2:0] ver;
    which = 4'($urandom_range(12));
    case (which)
      STAT_VERSION: begin
        ver = 3'($urandom_range(7));
        if (ver == PROTO_VERSION) ver = 3'd0;
        p.header_word[31:29] = ver;
      end
      STAT_DIAG:       p.header_word[28:24] = 5'($urandom_range(9, 31));
      STAT_POLL_FINAL: p.header_word[21:20] = 2'b11;
      STAT_AUTH:       p.header_word[18] = 1'b1;
      STAT_DEMAND:     p.header_word[17] = 1'b1;
      STAT_MULTIPOINT: p.header_word[16] = 1'b1;
      STAT_ZERO_MULT:  p.header_word[15:8] = 8'd0;
      STAT_LENGTH: begin
        p.header_word[7:0] = 8'($urandom_range(255));
        if (p.header_word[7:0] == PKT_LENGTH) p.header_word[7:0] = 8'd0;
      end
      STAT_ZERO_SDISC: p.sender_discr = '0;
      STAT_RDISC: begin
        if (p.header_word[23:22] >= ST_INIT && $urandom_range(1) == 1)
          p.receiver_discr = '0;
        else
          p.receiver_discr = p.local_discr ^ $urandom_range(1, 32'hFFFF_FFFF);
      end
      STAT_ECHO:       p.echo_rx_us = $urandom_range(1, 32'hFFFF_FFFF);
      // control plane independent flag is ignored, packet stays good
      default:         p.header_word[19] = ~p.header_word[19];
    endcase
    return p;
  endfunction

  // offer one word, hold it until taken, then record its reply
  task automatic send_pkt(input bfd_pkt_t p);
    while (!tx_steady && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {4'd0, p.fire_count, p.local_discr, p.echo_rx_us, p.required_rx_us,
                  p.desired_tx_us, p.receiver_discr, p.sender_discr, p.header_word,
                  p.session};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_replies.push_back(predict_reply(p));
  endtask

  task automatic wait_replies_drained;
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, steady stretches and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_req - 1;
      hold_req    = 0;
    end else if (rx_steady) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 6);
    end
  end

  // reply check against the oldest outstanding prediction
  always @(posedge clk) begin : reply_check
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status               = out_tdata[3:0];
      got.restart_tx_timer     = out_tdata[4];
      got.restart_detect_timer = out_tdata[5];
      got.fire_count_out       = out_tdata[13:6];
      got.change_mask          = out_tdata[19:14];
      got.remote_tx_ms         = out_tdata[42:20];
      got.remote_rx_ms         = out_tdata[65:43];
      if (expected_replies.size() == 0) begin
        $error("reply word with no packet outstanding: %h", out_tdata);
        fail_count++;
      end else begin
        want = expected_replies.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fail_count++;
        end
        if (got.restart_tx_timer !== want.restart_tx_timer) begin
          $error("restart_tx_timer: expected %0d, got %0d",
                 want.restart_tx_timer, got.restart_tx_timer);
          fail_count++;
        end
        if (got.restart_detect_timer !== want.restart_detect_timer) begin
          $error("restart_detect_timer: expected %0d, got %0d",
                 want.restart_detect_timer, got.restart_detect_timer);
          fail_count++;
        end
        if (got.fire_count_out !== want.fire_count_out) begin
          $error("fire_count_out: expected %0d, got %0d",
                 want.fire_count_out, got.fire_count_out);
          fail_count++;
        end
        if (got.change_mask !== want.change_mask) begin
          $error("change_mask: expected %b, got %b", want.change_mask, got.change_mask);
          fail_count++;
        end
        if (got.remote_tx_ms !== want.remote_tx_ms) begin
          $error("remote_tx_ms: expected %0d, got %0d", want.remote_tx_ms, got.remote_tx_ms);
          fail_count++;
        end
        if (got.remote_rx_ms !== want.remote_rx_ms) begin
          $error("remote_rx_ms: expected %0d, got %0d", want.remote_rx_ms, got.remote_rx_ms);
          fail_count++;
        end
        if (out_tdata[OUT_TDATA_W-1:66] !== '0) begin
          $error("pad: expected 0, got %h", out_tdata[OUT_TDATA_W-1:66]);
          fail_count++;
        end
      end
    end
  end

  // field extremes, every status code and the discriminator corner cases
  task automatic test_directed;
    bfd_pkt_t b;
    bfd_pkt_t p;
    b.session        = 4'd0;
    b.header_word    = make_header(PROTO_VERSION, 5'd0, ST_DOWN, 6'd0, 8'd3, PKT_LENGTH);
    b.sender_discr   = 32'd1;
    b.receiver_discr = 32'd0;
    b.desired_tx_us  = 32'd1000000;
    b.required_rx_us = 32'd1000000;
    b.echo_rx_us     = 32'd0;
    b.local_discr    = 32'hA5A5_0001;
    b.fire_count     = 8'd0;
    send_pkt(b);
    // same packet again: nothing changes
    send_pkt(b);
    p = b; p.header_word[31:29] = 3'd0;        send_pkt(p);
    p = b; p.header_word[31:29] = 3'd7;        send_pkt(p);
    p = b; p.header_word[28:24] = DIAG_MAX;    send_pkt(p);
    p = b; p.header_word[28:24] = 5'd9;        send_pkt(p);
    p = b; p.header_word[28:24] = 5'd31;       send_pkt(p);
    p = b; p.header_word[21:16] = 6'b110000;   send_pkt(p);
    p = b; p.header_word[21] = 1'b1;           send_pkt(p);
    p = b; p.header_word[20] = 1'b1;           send_pkt(p);
    // control plane independent bit has no effect
    p = b; p.header_word[19] = 1'b1;           send_pkt(p);
    p = b; p.header_word[18] = 1'b1;           send_pkt(p);
    p = b; p.header_word[17] = 1'b1;           send_pkt(p);
    p = b; p.header_word[16] = 1'b1;           send_pkt(p);
    p = b; p.header_word[15:8] = 8'd0;         send_pkt(p);
    p = b; p.header_word[7:0] = 8'd0;          send_pkt(p);
    p = b; p.header_word[7:0] = 8'd255;        send_pkt(p);
    p = b; p.sender_discr = 32'd0;             send_pkt(p);
    // zero your-discriminator in init, up and admin down states
    p = b; p.header_word[23:22] = ST_INIT;     send_pkt(p);
    p = b; p.header_word[23:22] = ST_UP;       send_pkt(p);
    p = b; p.header_word[23:22] = ST_ADMIN_DOWN; send_pkt(p);
    p = b; p.header_word[23:22] = ST_UP; p.receiver_discr = b.local_discr; send_pkt(p);
    p = b; p.receiver_discr = ~b.local_discr;  send_pkt(p);
    p = b; p.echo_rx_us = 32'hFFFF_FFFF;       send_pkt(p);
    // multiplier drop clamps a high fire count
    p = b; p.header_word[15:8] = 8'd1; p.fire_count = 8'd255; send_pkt(p);
    // largest values on the last session
    p.session        = 4'd15;
    p.header_word    = make_header(PROTO_VERSION, DIAG_MAX, ST_UP, 6'b101000, 8'd255,
                                   PKT_LENGTH);
    p.sender_discr   = 32'hFFFF_FFFF;
    p.receiver_discr = 32'hFFFF_FFFF;
    p.local_discr    = 32'hFFFF_FFFF;
    p.desired_tx_us  = 32'hFFFF_FFFF;
    p.required_rx_us = 32'hFFFF_FFFF;
    p.echo_rx_us     = 32'd0;
    p.fire_count     = 8'd255;
    send_pkt(p);
  endtask

  // mostly good packets with random content, some broken, some pure noise
  task automatic test_random_traffic(input int count);
    bfd_pkt_t   p;
    logic [3:0] s;
    int         pick;
    for (int i = 0; i < count; i++) begin
      // a few sessions see most of the traffic so repeats happen
      s = ($urandom_range(1) == 1) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
      pick = $urandom_range(99);
      p = gen_good_pkt(s);
      if (pick >= 92) begin
        p.header_word    = $urandom();
        p.sender_discr   = $urandom();
        p.receiver_discr = $urandom();
        p.desired_tx_us  = $urandom();
        p.required_rx_us = $urandom();
        p.echo_rx_us     = $urandom();
        p.local_discr    = $urandom();
      end else if (pick >= 80) begin
        p = break_pkt(p);
      end
      send_pkt(p);
    end
  endtask

  // receiver stops for a long stretch while packets keep coming
  task automatic test_output_hold(input int count);
    hold_req = HOLD_CYCLES;
    test_random_traffic(count);
  endtask

  // sender goes quiet until every reply is back, then resumes
  task automatic test_drain_pause(input int count);
    test_random_traffic(count);
    in_tvalid <= 1'b0;
    wait_replies_drained();
    @(posedge clk);
    test_random_traffic(count);
  endtask

  // back-to-back words with both sides always ready
  task automatic test_full_rate(input int count);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    test_random_traffic(count);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NUM_SESSIONS; i++) begin
      diag_store[i]  = '0;
      state_store[i] = '0;
      mult_store[i]  = '0;
      discr_store[i] = '0;
      tx_ms_store[i] = '0;
      rx_ms_store[i] = '0;
      local_id[i]    = $urandom();
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_traffic(700);
    test_output_hold(120);
    test_drain_pause(60);
    test_full_rate(250);
    test_random_traffic(600);

    in_tvalid <= 1'b0;
    wait_replies_drained();
    // leave room for any stray word
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ bfd_control_packet_receive_check.f @@
+incdir+src
src/bfdrc_pkg.sv
src/bfdrc_decode.sv
src/bfdrc_session_table.sv
src/bfd_control_packet_receive_check.sv
tb/sv/tb_bfd_control_packet_receive_check.sv
